/* rtl/core/pab_pkg.sv */
`timescale 1ns / 1ps

package pab_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 256;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int COORD_W = 8;
  localparam int COL_W   = 16;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 16;
  localparam int WORD_W  = 3 * SUM_W;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS = COL_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_IDX_SAMPLE_COUNT = 1'b0;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

endpackage

/* rtl/core/pab_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module pab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/pixel_accumulation_buffer_core.sv */
`timescale 1ns / 1ps

// Channel   Ports                                      Handshake
// input     in_mode, in_pixel_x/y, in_red/green/blue_in in_valid / in_ready
// result    out_red/green/blue_mean, out_zero_count_flag out_valid / out_ready
// config    cfg_psel .. cfg_pready (APB, one register) write in access phase
//
// Add: memory read, then saturating add and write back.
// Read: memory read, operand load, 16 restoring divider steps
//   (one quotient bit per cycle), result load into the output register.
// Clear and reset: a sweep of every word of the sum memory, one pixel a cycle,
//   with in_ready low. A finished result waits in the output register while
//   new words are taken; a read stalls only at its result load if that is full.
module pixel_accumulation_buffer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pab_pkg::MODE_W-1:0]        in_mode,
  input  logic [pab_pkg::COORD_W-1:0]       in_pixel_x,
  input  logic [pab_pkg::COORD_W-1:0]       in_pixel_y,
  input  logic [pab_pkg::COL_W-1:0]         in_red_in,
  input  logic [pab_pkg::COL_W-1:0]         in_green_in,
  input  logic [pab_pkg::COL_W-1:0]         in_blue_in,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pab_pkg::COL_W-1:0]         out_red_mean,
  output logic [pab_pkg::COL_W-1:0]         out_green_mean,
  output logic [pab_pkg::COL_W-1:0]         out_blue_mean,
  output logic                              out_zero_count_flag,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pab_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [pab_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [pab_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  import pab_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

  state_t                state_r;
  logic [ADDR_W-1:0]     clr_addr_r;
  logic [ADDR_W-1:0]     addr_r;
  logic                  in_frame_r;
  logic [CNT_W-1:0]      count_r;
  logic [STEP_W-1:0]     step_r;
  logic [COL_W-1:0]      smp_r   [3];
  logic [COL_W-1:0]      rem_r   [3];
  logic [COL_W-1:0]      dvd_r   [3];
  logic                  sat_r   [3];
  logic                  out_valid_r;
  logic [COL_W-1:0]      mean_r  [3];
  logic                  zflag_r;

  logic                  in_fire;
  logic                  cfg_wr;
  logic                  in_frame;
  logic [31:0]           idx_full;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [WORD_W-1:0]     mem_wdata;
  logic [WORD_W-1:0]     mem_rdata;
  logic [SUM_W-1:0]      sum_rd  [3];
  logic [SUM_W-1:0]      sum_add [3];
  logic [COL_W-1:0]      rem_nxt [3];
  logic [COL_W-1:0]      dvd_nxt [3];
  logic [COL_W-1:0]      mean_nxt[3];

  // Handshakes
  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Register readback
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1:2] == REG_IDX_SAMPLE_COUNT) begin
      cfg_prdata = CFG_DATA_W'(count_r);
    end
  end

  // Pixel address decode
  assign in_frame = (32'(in_pixel_x) < FRAME_WIDTH) && (32'(in_pixel_y) < FRAME_HEIGHT);
  assign idx_full = 32'(in_pixel_y) * FRAME_WIDTH + 32'(in_pixel_x);
  assign rd_addr  = ADDR_W'(idx_full);

  // Sum store: {red, green, blue}
  pab_ram #(
    .WIDTH(WORD_W),
    .DEPTH(PIX_COUNT)
  ) u_sums (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  // Read data split; an out-of-frame read sees zero sums
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_rd[c] = in_frame_r ? mem_rdata[(2-c)*SUM_W +: SUM_W] : '0;
    end
  end

  // Saturating adds for the write-back
  always_comb begin
    logic [SUM_W:0] t;
    for (int c = 0; c < 3; c++) begin
      t          = {1'b0, mem_rdata[(2-c)*SUM_W +: SUM_W]} + (SUM_W+1)'(smp_r[c]);
      sum_add[c] = t[SUM_W] ? '1 : t[SUM_W-1:0];
    end
  end

  // Memory write port: clear sweep or add write-back
  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_ADD);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : {sum_add[0], sum_add[1], sum_add[2]};

  // Restoring divider step, one quotient bit per channel
  always_comb begin
    logic [COL_W:0] t;
    logic           ge;
    for (int c = 0; c < 3; c++) begin
      t          = {rem_r[c], dvd_r[c][COL_W-1]};
      ge         = (t >= {1'b0, count_r});
      rem_nxt[c] = ge ? COL_W'(t - {1'b0, count_r}) : t[COL_W-1:0];
      dvd_nxt[c] = {dvd_r[c][COL_W-2:0], ge};
    end
  end

  // Final mean: zero count forces zero, quotient overflow saturates
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (count_r == '0) begin
        mean_nxt[c] = '0;
      end else if (sat_r[c]) begin
        mean_nxt[c] = '1;
      end else begin
        mean_nxt[c] = dvd_r[c];
      end
    end
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; a new one loaded in S_OUT keeps it set
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      // clear drops the sample count, else software may write it
      if (in_fire && (in_mode == MODE_CLEAR)) begin
        count_r <= '0;
      end else if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1:2] == REG_IDX_SAMPLE_COUNT)) begin
        count_r <= cfg_pwdata[CNT_W-1:0];
      end

      case (state_r)
        S_CLEAR: begin
          if (clr_addr_r == ADDR_W'(PIX_COUNT - 1)) begin
            clr_addr_r <= '0;
            state_r    <= S_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            addr_r     <= rd_addr;
            in_frame_r <= in_frame;
            smp_r[0]   <= in_red_in;
            smp_r[1]   <= in_green_in;
            smp_r[2]   <= in_blue_in;
            case (in_mode)
              MODE_ADD: begin
                if (in_frame) begin
                  state_r <= S_ADD;
                end
              end
              MODE_READ: begin
                state_r <= S_LOAD;
              end
              MODE_CLEAR: begin
                clr_addr_r <= '0;
                state_r    <= S_CLEAR;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end

        S_ADD: begin
          state_r <= S_IDLE;
        end

        // Load divider operands; high half at or above count means overflow
        S_LOAD: begin
          for (int c = 0; c < 3; c++) begin
            rem_r[c] <= sum_rd[c][SUM_W-1:COL_W];
            dvd_r[c] <= sum_rd[c][COL_W-1:0];
            sat_r[c] <= (sum_rd[c][SUM_W-1:COL_W] >= count_r);
          end
          step_r  <= '0;
          state_r <= S_DIV;
        end

        S_DIV: begin
          for (int c = 0; c < 3; c++) begin
            rem_r[c] <= rem_nxt[c];
            dvd_r[c] <= dvd_nxt[c];
          end
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            state_r <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            for (int c = 0; c < 3; c++) begin
              mean_r[c] <= mean_nxt[c];
            end
            zflag_r     <= (count_r == '0);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result word
  assign out_valid           = out_valid_r;
  assign out_red_mean        = mean_r[0];
  assign out_green_mean      = mean_r[1];
  assign out_blue_mean       = mean_r[2];
  assign out_zero_count_flag = zflag_r;

endmodule
